[rtl/b2ss_pkg.sv]
// Shared constants and the segment pattern lookup for the seven-segment scan block.
`default_nettype none

package b2ss_pkg;

    localparam int VALUE_W   = 16;
    localparam int SEG_W     = 8;
    localparam int POS_W     = 3;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 5;
    localparam int WEIGHT_W  = 17;

    // One pipeline stage per extracted digit; the units digit is what remains.
    localparam int NUM_STAGES = DIGITS - 1;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

    // Place weights, ten-thousands down to tens.
    localparam logic [WEIGHT_W-1:0] PLACE_WEIGHT [NUM_STAGES] = '{
        WEIGHT_W'(10000), WEIGHT_W'(1000), WEIGHT_W'(100), WEIGHT_W'(10)
    };

    // Active-low segment pattern of one decimal digit. Codes above nine show as nine.
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pattern;
        unique case (digit)
            4'd0:    pattern = 8'hC0;
            4'd1:    pattern = 8'hEE;
            4'd2:    pattern = 8'h85;
            4'd3:    pattern = 8'h86;
            4'd4:    pattern = 8'hAA;
            4'd5:    pattern = 8'h92;
            4'd6:    pattern = 8'h90;
            4'd7:    pattern = 8'hCA;
            4'd8:    pattern = 8'h80;
            default: pattern = 8'h82;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

[rtl/binary_to_seven_segment_scan.sv]
// Top level: pipelined binary to five-digit seven-segment scan with a digit serializer.
//
// Usage: the input channel (i_in_valid, o_in_ready, i_value) takes one unsigned
// 16-bit value per transfer. The output channel (o_out_valid, i_out_ready)
// returns five transfers for every value, ten-thousands digit first and units
// digit last, each carrying the active-low segment byte, the digit position
// (0 to 4) and a flag that marks the units digit. Leading zeros are shown.
// A value passes through the four digit stages, the serializer and the output
// register before its first digit is presented; its other digits follow in
// order. The single output channel carries one digit per cycle while the
// receiver keeps up and so limits throughput; the four digit stages take a new
// value in every cycle until they fill, buffering up to four values while the
// serializer works, so the input side keeps accepting during that time.
// Reset (synchronous, active low) empties every stage, the serializer and the
// output register; nothing else needs clearing. When the receiver holds
// i_out_ready low, the output register holds its transfer, the serializer
// holds its digit, and back-pressure ripples stage by stage to o_in_ready;
// no digit is lost or repeated.
`default_nettype none

module binary_to_seven_segment_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [b2ss_pkg::VALUE_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [b2ss_pkg::SEG_W-1:0]         o_segments,
    output logic [b2ss_pkg::POS_W-1:0]         o_digit_position,
    output logic                               o_last_digit
);

    import b2ss_pkg::*;

    // Digit stages: stage s extracts digit s by comparing its remainder
    // against the nine multiples of the place weight and subtracting the
    // largest that fits. Each stage carries its own valid bit.
    logic                 r_vld  [NUM_STAGES];
    logic [VALUE_W-1:0]   r_rest [NUM_STAGES];
    logic [DIGIT_W-1:0]   r_dig  [NUM_STAGES][DIGITS];

    logic                 stage_free [NUM_STAGES];
    logic                 stage_in_vld [NUM_STAGES];
    logic [VALUE_W-1:0]   stage_in_rest [NUM_STAGES];
    logic [VALUE_W-1:0]   n_rest [NUM_STAGES];
    logic [DIGIT_W-1:0]   n_digit [NUM_STAGES];

    // Serializer: holds the five digits of one value and steps through them.
    logic                 r_ser_vld;
    logic [DIGIT_W-1:0]   r_ser_dig [DIGITS];
    logic [POS_W-1:0]     r_pos;

    // Output register.
    logic                 r_out_vld;
    logic [SEG_W-1:0]     r_segments;
    logic [POS_W-1:0]     r_digit_position;
    logic                 r_last_digit;

    logic out_free;
    logic ser_fire;
    logic ser_free;

    assign out_free = !r_out_vld || i_out_ready;
    assign ser_fire = r_ser_vld && out_free;
    assign ser_free = !r_ser_vld || (ser_fire && (r_pos == LAST_POS));

    // A stage can load when it is empty or its content moves on this cycle.
    always_comb begin
        stage_free[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || ser_free;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            stage_free[s] = !r_vld[s] || stage_free[s+1];
        end
    end

    always_comb begin
        stage_in_vld[0]  = i_in_valid;
        stage_in_rest[0] = i_value;
        for (int s = 1; s < NUM_STAGES; s++) begin
            stage_in_vld[s]  = r_vld[s-1];
            stage_in_rest[s] = r_rest[s-1];
        end
    end

    assign o_in_ready = stage_free[0];

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        logic [WEIGHT_W-1:0] n_sub;

        always_comb begin
            n_digit[s] = '0;
            n_sub      = '0;
            for (int k = 1; k < 10; k++) begin
                if ({1'b0, stage_in_rest[s]} >= WEIGHT_W'(k) * PLACE_WEIGHT[s]) begin
                    n_digit[s] = DIGIT_W'(k);
                    n_sub      = WEIGHT_W'(k) * PLACE_WEIGHT[s];
                end
            end
            n_rest[s] = stage_in_rest[s] - n_sub[VALUE_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (stage_free[s]) begin
                r_vld[s] <= stage_in_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_free[s] && stage_in_vld[s]) begin
                r_rest[s] <= n_rest[s];
                for (int d = 0; d < DIGITS; d++) begin
                    if (d == s) begin
                        r_dig[s][d] <= n_digit[s];
                    end else if (d < s) begin
                        r_dig[s][d] <= r_dig[(s > 0) ? s - 1 : 0][d];
                    end
                end
            end
        end
    end

    // Serializer control. A new value loads when the serializer is empty or
    // hands its units digit to the output register in this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_pos     <= '0;
        end else if (ser_free) begin
            r_ser_vld <= r_vld[NUM_STAGES-1];
            r_pos     <= '0;
        end else if (ser_fire) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    // The last stage's remainder is below ten and is the units digit.
    always_ff @(posedge i_clk) begin
        if (ser_free && r_vld[NUM_STAGES-1]) begin
            for (int d = 0; d < NUM_STAGES; d++) begin
                r_ser_dig[d] <= r_dig[NUM_STAGES-1][d];
            end
            r_ser_dig[DIGITS-1] <= r_rest[NUM_STAGES-1][DIGIT_W-1:0];
        end
    end

    // Output register: takes one digit per cycle while the receiver keeps up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_ser_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_fire) begin
            r_segments       <= seg_of(r_ser_dig[r_pos]);
            r_digit_position <= r_pos;
            r_last_digit     <= (r_pos == LAST_POS);
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_segments       = r_segments;
    assign o_digit_position = r_digit_position;
    assign o_last_digit     = r_last_digit;

endmodule

`default_nettype wire
